/* sv/exprtok_pkg.sv */
// Shared types and constants for the expression tokenizer
`timescale 1ns / 1ps

package exprtok_pkg;

  // default limit on characters per expression
  localparam int MAX_CHARS_DEF = 4096;

  // result field widths
  localparam int KIND_W  = 4;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;

  // output queue depth, room for two tokens from one word plus two in flight
  localparam int QDEPTH = 4;

  // token kinds
  typedef enum logic [KIND_W-1:0] {
    TK_NUMBER = 4'd0,
    TK_NAME   = 4'd1,
    TK_LPAREN = 4'd2,
    TK_RPAREN = 4'd3,
    TK_COMMA  = 4'd4,
    TK_ADD    = 4'd5,
    TK_SUB    = 4'd6,
    TK_MUL    = 4'd7,
    TK_DIV    = 4'd8,
    TK_POW    = 4'd9,
    TK_NEG    = 4'd10,
    TK_ERROR  = 4'd11,
    TK_END    = 4'd12
  } tok_kind_t;

  // lexer modes
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_NUMBER = 3'd1,
    MODE_NAME   = 3'd2,
    MODE_MINUS  = 3'd3,
    MODE_DRAIN  = 3'd4
  } mode_t;

  // one result token
  typedef struct packed {
    tok_kind_t          kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               last;
  } tok_t;

  // character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_EXP_UC = 8'h45;
  localparam logic [7:0] CH_EXP_LC = 8'h65;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A_UC   = 8'h41;
  localparam logic [7:0] CH_Z_UC   = 8'h5A;
  localparam logic [7:0] CH_A_LC   = 8'h61;
  localparam logic [7:0] CH_Z_LC   = 8'h7A;

endpackage

/* sv/expression_tokenizer.sv */
// Streaming lexer for infix arithmetic expressions, top level
//
// One word carries one expression character, or the end marker. Each word
// is lexed in the cycle it is accepted and yields zero, one or two tokens
// (kind, start, length, last) that go into a four-entry output queue. With
// the queue empty, the first token of a word shows on the out_ ports in the
// cycle after the word is accepted; behind queued tokens it waits until all
// of them have gone out. A word is taken whenever the queue has two free
// entries, so with the output side draining one token per cycle the block
// takes one word per cycle. Words that yield two tokens are: a pending
// number, name or minus ended by a character that is a token of its own or
// by a stray byte, a pending token cut off at the length limit, and the end
// marker after a pending token. The output port's one token per cycle sets
// the long-run rate.
// Positions count from 0 per expression; characters past MAX_CHARS give one
// error token of start 0 and length 0, after which input is dropped until
// the end marker, which always closes with an end token flagged last.
`timescale 1ns / 1ps

module expression_tokenizer #(
  parameter int MAX_CHARS = exprtok_pkg::MAX_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_character,
  input  logic                            in_end_of_expr,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [exprtok_pkg::KIND_W-1:0]  out_token_kind,
  output logic [exprtok_pkg::START_W-1:0] out_token_start,
  output logic [exprtok_pkg::LEN_W-1:0]   out_token_length,
  output logic                            out_is_last
);

  localparam int PW = $clog2(MAX_CHARS + 1);
  localparam int SW = (PW > exprtok_pkg::START_W) ? PW : exprtok_pkg::START_W;
  localparam int LW = (PW > exprtok_pkg::LEN_W) ? PW : exprtok_pkg::LEN_W;
  localparam int QD = exprtok_pkg::QDEPTH;
  localparam int CW = $clog2(QD + 1);

  // lexer state
  exprtok_pkg::mode_t mode_r, mode_nxt;
  logic               dot_r, dot_nxt;
  logic               exp_r, exp_nxt;
  logic               esign_r, esign_nxt;
  logic [PW-1:0]      pstart_r, pstart_nxt;
  logic [PW-1:0]      cpos_r, cpos_nxt;
  logic               unary_r, unary_nxt;

  // output queue
  exprtok_pkg::tok_t q_r [QD];
  exprtok_pkg::tok_t q_nxt [QD];
  logic [CW-1:0]     cnt_r, cnt_nxt;

  logic [7:0] c;
  logic       in_fire, out_fire;
  logic       is_dig, is_let, is_dot, is_sign, is_exp, is_ws;
  logic       num_ext, name_ext, minus_ext;
  logic       cpos_full;

  assign c         = in_character;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (cnt_r <= CW'(QD - 2));
  assign cpos_full = (cpos_r >= PW'(MAX_CHARS));

  // character classes
  assign is_dig  = (c >= exprtok_pkg::CH_0) && (c <= exprtok_pkg::CH_9);
  assign is_let  = ((c >= exprtok_pkg::CH_A_UC) && (c <= exprtok_pkg::CH_Z_UC)) ||
                   ((c >= exprtok_pkg::CH_A_LC) && (c <= exprtok_pkg::CH_Z_LC));
  assign is_dot  = (c == exprtok_pkg::CH_DOT);
  assign is_sign = (c == exprtok_pkg::CH_PLUS) || (c == exprtok_pkg::CH_MINUS);
  assign is_exp  = (c == exprtok_pkg::CH_EXP_UC) || (c == exprtok_pkg::CH_EXP_LC);
  assign is_ws   = (c == exprtok_pkg::CH_SPACE) || (c == exprtok_pkg::CH_TAB);

  // can the character extend the pending token
  assign num_ext   = (esign_r && is_sign) || is_dig || (is_dot && !dot_r && !exp_r) ||
                     (is_exp && !exp_r);
  assign name_ext  = is_let || is_dig || (c == exprtok_pkg::CH_UNDER);
  assign minus_ext = is_dig || is_dot;

  // pending token, ending just before the current position
  exprtok_pkg::tok_t fl_tok;
  logic              fl_has;
  logic [PW-1:0]     fl_diff;
  logic [LW-1:0]     fl_diff_ext;
  logic [SW-1:0]     pstart_ext;
  logic [SW-1:0]     cpos_ext;

  assign fl_diff     = cpos_r - pstart_r;
  assign fl_diff_ext = LW'(fl_diff);
  assign pstart_ext  = SW'(pstart_r);
  assign cpos_ext    = SW'(cpos_r);
  assign fl_has      = (mode_r == exprtok_pkg::MODE_NUMBER) ||
                       (mode_r == exprtok_pkg::MODE_NAME) ||
                       (mode_r == exprtok_pkg::MODE_MINUS);

  always_comb begin
    fl_tok.start = pstart_ext[exprtok_pkg::START_W-1:0];
    fl_tok.last  = 1'b0;
    case (mode_r)
      exprtok_pkg::MODE_NUMBER: begin
        fl_tok.kind   = exprtok_pkg::TK_NUMBER;
        fl_tok.length = fl_diff_ext[exprtok_pkg::LEN_W-1:0];
      end
      exprtok_pkg::MODE_NAME: begin
        fl_tok.kind   = exprtok_pkg::TK_NAME;
        fl_tok.length = fl_diff_ext[exprtok_pkg::LEN_W-1:0];
      end
      default: begin
        fl_tok.kind   = exprtok_pkg::TK_NEG;
        fl_tok.length = exprtok_pkg::LEN_W'(1);
      end
    endcase
  end

  // lexing of a character with nothing pending (after any flush)
  exprtok_pkg::mode_t    lx_mode;
  exprtok_pkg::tok_kind_t lx_kind;
  logic                  lx_v, lx_unary, lx_pend, lx_num, u0;

  assign u0 = (mode_r == exprtok_pkg::MODE_MINUS) ? 1'b1 :
              (mode_r == exprtok_pkg::MODE_IDLE) ? unary_r : 1'b0;

  always_comb begin
    lx_mode  = exprtok_pkg::MODE_IDLE;
    lx_kind  = exprtok_pkg::TK_ERROR;
    lx_v     = 1'b0;
    lx_unary = u0;
    lx_pend  = 1'b0;
    lx_num   = 1'b0;
    case (c)
      exprtok_pkg::CH_LPAREN: lx_kind = exprtok_pkg::TK_LPAREN;
      exprtok_pkg::CH_RPAREN: lx_kind = exprtok_pkg::TK_RPAREN;
      exprtok_pkg::CH_COMMA:  lx_kind = exprtok_pkg::TK_COMMA;
      exprtok_pkg::CH_PLUS:   lx_kind = exprtok_pkg::TK_ADD;
      exprtok_pkg::CH_STAR:   lx_kind = exprtok_pkg::TK_MUL;
      exprtok_pkg::CH_SLASH:  lx_kind = exprtok_pkg::TK_DIV;
      exprtok_pkg::CH_CARET:  lx_kind = exprtok_pkg::TK_POW;
      default:                lx_kind = exprtok_pkg::TK_ERROR;
    endcase
    if (is_ws) begin
      lx_v = 1'b0;
    end else if (lx_kind != exprtok_pkg::TK_ERROR) begin
      lx_v     = 1'b1;
      lx_unary = (lx_kind != exprtok_pkg::TK_RPAREN);
    end else if (c == exprtok_pkg::CH_MINUS) begin
      if (u0) begin
        lx_mode = exprtok_pkg::MODE_MINUS;
        lx_pend = 1'b1;
      end else begin
        lx_v     = 1'b1;
        lx_kind  = exprtok_pkg::TK_SUB;
        lx_unary = 1'b1;
      end
    end else if (is_dig || is_dot) begin
      lx_mode = exprtok_pkg::MODE_NUMBER;
      lx_pend = 1'b1;
      lx_num  = 1'b1;
    end else if (is_let || (c == exprtok_pkg::CH_UNDER)) begin
      lx_mode = exprtok_pkg::MODE_NAME;
      lx_pend = 1'b1;
    end else begin
      lx_v    = 1'b1;
      lx_mode = exprtok_pkg::MODE_DRAIN;
    end
  end

  // does the character end the pending token
  logic need_flush;
  always_comb begin
    case (mode_r)
      exprtok_pkg::MODE_NUMBER: need_flush = !num_ext;
      exprtok_pkg::MODE_NAME:   need_flush = !name_ext;
      exprtok_pkg::MODE_MINUS:  need_flush = !minus_ext;
      default:                  need_flush = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    dot_nxt    = dot_r;
    exp_nxt    = exp_r;
    esign_nxt  = esign_r;
    pstart_nxt = pstart_r;
    cpos_nxt   = cpos_r;
    unary_nxt  = unary_r;
    if (in_fire) begin
      if (in_end_of_expr) begin
        mode_nxt   = exprtok_pkg::MODE_IDLE;
        dot_nxt    = 1'b0;
        exp_nxt    = 1'b0;
        esign_nxt  = 1'b0;
        pstart_nxt = '0;
        cpos_nxt   = '0;
        unary_nxt  = 1'b1;
      end else if (mode_r == exprtok_pkg::MODE_DRAIN) begin
        mode_nxt = exprtok_pkg::MODE_DRAIN;
      end else if (cpos_full) begin
        mode_nxt = exprtok_pkg::MODE_DRAIN;
      end else begin
        cpos_nxt = cpos_r + PW'(1);
        if (mode_r == exprtok_pkg::MODE_NUMBER && num_ext) begin
          // sign, digit, dot or exponent, tried in that order
          if (esign_r && is_sign) begin
            esign_nxt = 1'b0;
          end else if (is_dig) begin
            esign_nxt = 1'b0;
          end else if (is_dot && !dot_r && !exp_r) begin
            dot_nxt   = 1'b1;
            esign_nxt = 1'b0;
          end else begin
            exp_nxt   = 1'b1;
            esign_nxt = 1'b1;
          end
        end else if (mode_r == exprtok_pkg::MODE_NAME && name_ext) begin
          mode_nxt = exprtok_pkg::MODE_NAME;
        end else if (mode_r == exprtok_pkg::MODE_MINUS && minus_ext) begin
          mode_nxt  = exprtok_pkg::MODE_NUMBER;
          dot_nxt   = is_dot;
          exp_nxt   = 1'b0;
          esign_nxt = 1'b0;
        end else begin
          mode_nxt  = lx_mode;
          unary_nxt = lx_unary;
          if (lx_pend) begin
            pstart_nxt = cpos_r;
          end
          if (lx_num) begin
            dot_nxt   = is_dot;
            exp_nxt   = 1'b0;
            esign_nxt = 1'b0;
          end
        end
      end
    end
  end

  // tokens produced by this word
  exprtok_pkg::tok_t t0, t1, end_tok, err_tok, lx_tok;
  logic [1:0]        ntok;

  always_comb begin
    end_tok.kind   = exprtok_pkg::TK_END;
    end_tok.start  = '0;
    end_tok.length = '0;
    end_tok.last   = 1'b1;
    err_tok.kind   = exprtok_pkg::TK_ERROR;
    err_tok.start  = '0;
    err_tok.length = '0;
    err_tok.last   = 1'b0;
    lx_tok.kind    = lx_kind;
    lx_tok.start   = cpos_ext[exprtok_pkg::START_W-1:0];
    lx_tok.length  = exprtok_pkg::LEN_W'(1);
    lx_tok.last    = 1'b0;
  end

  always_comb begin
    t0   = fl_tok;
    t1   = end_tok;
    ntok = 2'd0;
    if (in_fire) begin
      if (in_end_of_expr) begin
        if (fl_has) begin
          ntok = 2'd2;
        end else begin
          t0   = end_tok;
          ntok = 2'd1;
        end
      end else if (mode_r == exprtok_pkg::MODE_DRAIN) begin
        ntok = 2'd0;
      end else if (cpos_full) begin
        t1 = err_tok;
        if (fl_has) begin
          ntok = 2'd2;
        end else begin
          t0   = err_tok;
          ntok = 2'd1;
        end
      end else if (mode_r == exprtok_pkg::MODE_IDLE || need_flush) begin
        t1 = lx_tok;
        if (need_flush && lx_v) begin
          ntok = 2'd2;
        end else if (need_flush) begin
          ntok = 2'd1;
        end else if (lx_v) begin
          t0   = lx_tok;
          ntok = 2'd1;
        end
      end
    end
  end

  // output queue: entry 0 is the head, shift on pop, append behind the tail
  logic [CW-1:0] base;
  assign base = cnt_r - CW'(out_fire);

  always_comb begin
    for (int i = 0; i < QD; i++) begin
      if (out_fire && (i < QD - 1)) begin
        q_nxt[i] = q_r[(i < QD - 1) ? i + 1 : i];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if ((ntok != 2'd0) && (CW'(i) == base)) begin
        q_nxt[i] = t0;
      end
      if ((ntok == 2'd2) && (CW'(i) == base + CW'(1))) begin
        q_nxt[i] = t1;
      end
    end
    cnt_nxt = base + CW'(ntok);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= exprtok_pkg::MODE_IDLE;
      dot_r    <= 1'b0;
      exp_r    <= 1'b0;
      esign_r  <= 1'b0;
      pstart_r <= '0;
      cpos_r   <= '0;
      unary_r  <= 1'b1;
      cnt_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      dot_r    <= dot_nxt;
      exp_r    <= exp_nxt;
      esign_r  <= esign_nxt;
      pstart_r <= pstart_nxt;
      cpos_r   <= cpos_nxt;
      unary_r  <= unary_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // head of the queue drives the result word
  assign out_valid        = (cnt_r != '0);
  assign out_token_kind   = q_r[0].kind;
  assign out_token_start  = q_r[0].start;
  assign out_token_length = q_r[0].length;
  assign out_is_last      = q_r[0].last;

endmodule

/* sv/exprtok_checker.sv */
// Port-level checks for the expression tokenizer, bound to the top level
`timescale 1ns / 1ps

module exprtok_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_end_of_expr,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [exprtok_pkg::KIND_W-1:0]  out_token_kind,
  input logic [exprtok_pkg::START_W-1:0] out_token_start,
  input logic [exprtok_pkg::LEN_W-1:0]   out_token_length,
  input logic                            out_is_last
);

  // last flag rides on end tokens and on nothing else
  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_last == (out_token_kind == exprtok_pkg::TK_END)))
    else $error("last flag and end kind disagree");

  // end token carries no position
  a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_last) |-> (out_token_start == '0 && out_token_length == '0))
    else $error("end token with nonzero start or length");

  // every word is lexed at once: an accepted end marker shows a result next cycle
  a_end_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_end_of_expr) |=> out_valid)
    else $error("no result after end marker");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_token_kind) &&
      $stable(out_token_start) && $stable(out_token_length) && $stable(out_is_last)))
    else $error("result word changed while stalled");

endmodule

bind expression_tokenizer exprtok_checker u_exprtok_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_end_of_expr   (in_end_of_expr),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_token_kind   (out_token_kind),
  .out_token_start  (out_token_start),
  .out_token_length (out_token_length),
  .out_is_last      (out_is_last)
);

/* dv/expression_tokenizer_test.sv */
// Self-checking testbench for the expression tokenizer, with a built-in lexer predictor
`timescale 1ns / 1ps

module expression_tokenizer_test;

  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_WORDS = 1500;
  localparam int TAIL_CYCLES  = 16;

  // tracks the lexer state and the tokens still owed by the block
  class tokenizer_scoreboard;
    exprtok_pkg::tok_t expected_q[$];
    int unsigned errors;
    int unsigned tokens_checked;
    int unsigned words_taken;
    int unsigned expressions;
    int unsigned longest;
    bit [15:0] kinds_seen;

    exprtok_pkg::mode_t mode;
    bit seen_dot;
    bit seen_exp;
    bit exp_sign_ok;
    int unsigned pend_start;
    int unsigned pos;
    bit unary;

    function new();
      clear_lexer();
    endfunction

    function void clear_lexer();
      mode        = exprtok_pkg::MODE_IDLE;
      seen_dot    = 1'b0;
      seen_exp    = 1'b0;
      exp_sign_ok = 1'b0;
      pend_start  = 0;
      pos         = 0;
      unary       = 1'b1;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= exprtok_pkg::CH_0 && c <= exprtok_pkg::CH_9;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= exprtok_pkg::CH_A_UC && c <= exprtok_pkg::CH_Z_UC) ||
             (c >= exprtok_pkg::CH_A_LC && c <= exprtok_pkg::CH_Z_LC);
    endfunction

    function void emit(exprtok_pkg::tok_kind_t kind, int unsigned start,
                       int unsigned length, bit last);
      exprtok_pkg::tok_t t;
      t.kind   = kind;
      t.start  = start[exprtok_pkg::START_W-1:0];
      t.length = length[exprtok_pkg::LEN_W-1:0];
      t.last   = last;
      expected_q.insert(expected_q.size(), t);
    endfunction

    // close out a pending number, name or minus ending just before pos
    function void flush();
      case (mode)
        exprtok_pkg::MODE_NUMBER: begin
          emit(exprtok_pkg::TK_NUMBER, pend_start, pos - pend_start, 1'b0);
          unary = 1'b0;
        end
        exprtok_pkg::MODE_NAME: begin
          emit(exprtok_pkg::TK_NAME, pend_start, pos - pend_start, 1'b0);
          unary = 1'b0;
        end
        exprtok_pkg::MODE_MINUS: begin
          emit(exprtok_pkg::TK_NEG, pend_start, 1, 1'b0);
          unary = 1'b1;
        end
        default: ;
      endcase
      if (mode != exprtok_pkg::MODE_DRAIN) mode = exprtok_pkg::MODE_IDLE;
    endfunction

    function void open_number(logic [7:0] c);
      mode        = exprtok_pkg::MODE_NUMBER;
      seen_dot    = (c == exprtok_pkg::CH_DOT);
      seen_exp    = 1'b0;
      exp_sign_ok = 1'b0;
    endfunction

    // character with nothing pending
    function void lex_fresh(logic [7:0] c);
      exprtok_pkg::tok_kind_t kind;
      bit single;
      kind   = exprtok_pkg::TK_ERROR;
      single = 1'b1;
      case (c)
        exprtok_pkg::CH_SPACE, exprtok_pkg::CH_TAB: return;
        exprtok_pkg::CH_LPAREN: kind = exprtok_pkg::TK_LPAREN;
        exprtok_pkg::CH_RPAREN: kind = exprtok_pkg::TK_RPAREN;
        exprtok_pkg::CH_COMMA:  kind = exprtok_pkg::TK_COMMA;
        exprtok_pkg::CH_PLUS:   kind = exprtok_pkg::TK_ADD;
        exprtok_pkg::CH_STAR:   kind = exprtok_pkg::TK_MUL;
        exprtok_pkg::CH_SLASH:  kind = exprtok_pkg::TK_DIV;
        exprtok_pkg::CH_CARET:  kind = exprtok_pkg::TK_POW;
        default:                single = 1'b0;
      endcase
      if (single) begin
        emit(kind, pos, 1, 1'b0);
        unary = (kind != exprtok_pkg::TK_RPAREN);
      end else if (c == exprtok_pkg::CH_MINUS) begin
        if (unary) begin
          mode       = exprtok_pkg::MODE_MINUS;
          pend_start = pos;
        end else begin
          emit(exprtok_pkg::TK_SUB, pos, 1, 1'b0);
          unary = 1'b1;
        end
      end else if (is_digit(c) || c == exprtok_pkg::CH_DOT) begin
        pend_start = pos;
        open_number(c);
      end else if (is_letter(c) || c == exprtok_pkg::CH_UNDER) begin
        pend_start = pos;
        mode       = exprtok_pkg::MODE_NAME;
      end else begin
        emit(exprtok_pkg::TK_ERROR, pos, 1, 1'b0);
        mode = exprtok_pkg::MODE_DRAIN;
      end
    endfunction

    function void lex_char(logic [7:0] c);
      case (mode)
        exprtok_pkg::MODE_NUMBER: begin
          if (exp_sign_ok && (c == exprtok_pkg::CH_PLUS || c == exprtok_pkg::CH_MINUS)) begin
            exp_sign_ok = 1'b0;
            return;
          end
          if (is_digit(c)) begin
            exp_sign_ok = 1'b0;
            return;
          end
          if (c == exprtok_pkg::CH_DOT && !seen_dot && !seen_exp) begin
            seen_dot    = 1'b1;
            exp_sign_ok = 1'b0;
            return;
          end
          if ((c == exprtok_pkg::CH_EXP_UC || c == exprtok_pkg::CH_EXP_LC) && !seen_exp) begin
            seen_exp    = 1'b1;
            exp_sign_ok = 1'b1;
            return;
          end
          flush();
        end
        exprtok_pkg::MODE_NAME: begin
          if (is_letter(c) || is_digit(c) || c == exprtok_pkg::CH_UNDER) return;
          flush();
        end
        exprtok_pkg::MODE_MINUS: begin
          if (is_digit(c) || c == exprtok_pkg::CH_DOT) begin
            open_number(c);
            return;
          end
          flush();
        end
        exprtok_pkg::MODE_DRAIN: return;
        default: ;
      endcase
      lex_fresh(c);
    endfunction

    // accepted input word: work out the tokens it causes
    function void take_word(logic [7:0] c, logic end_mark);
      words_taken++;
      if (end_mark) begin
        expressions++;
        flush();
        emit(exprtok_pkg::TK_END, 0, 0, 1'b1);
        clear_lexer();
        return;
      end
      if (mode == exprtok_pkg::MODE_DRAIN) return;
      if (pos >= exprtok_pkg::MAX_CHARS_DEF) begin
        flush();
        emit(exprtok_pkg::TK_ERROR, 0, 0, 1'b0);
        mode = exprtok_pkg::MODE_DRAIN;
        return;
      end
      lex_char(c);
      pos++;
    endfunction

    // accepted output word: compare with the oldest expected token
    function void check_token(exprtok_pkg::tok_t got);
      exprtok_pkg::tok_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected token kind %0d start %0d length %0d last %0d",
               got.kind, got.start, got.length, got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      tokens_checked++;
      kinds_seen[want.kind] = 1'b1;
      if (want.length > longest) longest = want.length;
      if (got.kind !== want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.start !== want.start) begin
        $error("token_start: expected %0d, got %0d", want.start, got.start);
        errors++;
      end
      if (got.length !== want.length) begin
        $error("token_length: expected %0d, got %0d", want.length, got.length);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("is_last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [7:0]                      in_character;
  logic                            in_end_of_expr;
  logic                            out_valid;
  logic                            out_ready;
  logic [exprtok_pkg::KIND_W-1:0]  out_token_kind;
  logic [exprtok_pkg::START_W-1:0] out_token_start;
  logic [exprtok_pkg::LEN_W-1:0]   out_token_length;
  logic                            out_is_last;

  tokenizer_scoreboard sb = new();

  logic [7:0] expr_chars[$];
  int  burst_left = 0;
  bit  steady = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_active = 1'b0;

  expression_tokenizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_character     (in_character),
    .in_end_of_expr   (in_end_of_expr),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_is_last      (out_is_last)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // input word monitor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.take_word(in_character, in_end_of_expr);
  end

  // output word monitor
  always @(posedge clk) begin
    exprtok_pkg::tok_t got;
    if (rst_n && out_valid && out_ready) begin
      got.kind   = exprtok_pkg::tok_kind_t'(out_token_kind);
      got.start  = out_token_start;
      got.length = out_token_length;
      got.last   = out_is_last;
      sb.check_token(got);
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int stall_mode;
    int run_len;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end else begin
        stall_mode = $urandom_range(0, 3);
        run_len    = $urandom_range(1, 60);
        repeat (run_len) begin
          case (stall_mode)
            0, 1:    out_ready <= 1'b1;
            2:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // sender bursts and gaps
  task automatic pace();
    int gap;
    if (steady) return;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 25) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
  endtask

  task automatic send_word(logic [7:0] c, logic end_mark);
    pace();
    in_valid       <= 1'b1;
    in_character   <= c;
    in_end_of_expr <= end_mark;
    do @(posedge clk); while (!in_ready);
  endtask

  // every character of the current expression, then the end marker
  task automatic send_expr();
    foreach (expr_chars[i]) send_word(expr_chars[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // hold the input off until every owed token has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic void add_char(logic [7:0] c);
    expr_chars.insert(expr_chars.size(), c);
  endfunction

  function automatic void load_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic void add_digits(int n);
    repeat (n) add_char(exprtok_pkg::CH_0 + 8'($urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] pick_letter();
    return $urandom_range(0, 1) ? exprtok_pkg::CH_A_UC + 8'($urandom_range(0, 25))
                                : exprtok_pkg::CH_A_LC + 8'($urandom_range(0, 25));
  endfunction

  // number with optional dot and exponent, now and then malformed
  function automatic void add_number();
    if ($urandom_range(0, 3) == 0) begin
      add_char(exprtok_pkg::CH_DOT);
      add_digits($urandom_range(1, 3));
    end else begin
      add_digits($urandom_range(1, 4));
      if ($urandom_range(0, 2) == 0) begin
        add_char(exprtok_pkg::CH_DOT);
        add_digits($urandom_range(0, 3));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      add_char($urandom_range(0, 1) ? exprtok_pkg::CH_EXP_UC : exprtok_pkg::CH_EXP_LC);
      case ($urandom_range(0, 2))
        1: add_char(exprtok_pkg::CH_PLUS);
        2: add_char(exprtok_pkg::CH_MINUS);
        default: ;
      endcase
      add_digits($urandom_range(0, 2));
    end
    if ($urandom_range(0, 9) == 0)
      add_char($urandom_range(0, 1) ? exprtok_pkg::CH_DOT : exprtok_pkg::CH_EXP_LC);
  endfunction

  function automatic void add_name();
    int n;
    int r;
    n = $urandom_range(0, 6);
    add_char($urandom_range(0, 4) == 0 ? exprtok_pkg::CH_UNDER : pick_letter());
    repeat (n) begin
      r = $urandom_range(0, 5);
      if (r == 0) add_char(exprtok_pkg::CH_UNDER);
      else if (r < 3) add_digits(1);
      else add_char(pick_letter());
    end
  endfunction

  function automatic void add_space();
    if ($urandom_range(0, 3) == 0)
      add_char($urandom_range(0, 1) ? exprtok_pkg::CH_SPACE : exprtok_pkg::CH_TAB);
  endfunction

  // one operand with its leading operator, unary minus and parentheses
  function automatic void add_term(bit first, ref int depth);
    logic [7:0] binops[6];
    binops = '{exprtok_pkg::CH_PLUS, exprtok_pkg::CH_MINUS, exprtok_pkg::CH_STAR,
               exprtok_pkg::CH_SLASH, exprtok_pkg::CH_CARET, exprtok_pkg::CH_COMMA};
    if (!first) add_char(binops[$urandom_range(0, 5)]);
    add_space();
    if ($urandom_range(0, 3) == 0) add_char(exprtok_pkg::CH_MINUS);
    if ($urandom_range(0, 4) == 0) begin
      add_char(exprtok_pkg::CH_LPAREN);
      depth++;
      if ($urandom_range(0, 3) == 0) add_char(exprtok_pkg::CH_MINUS);
    end
    if ($urandom_range(0, 1)) add_number();
    else add_name();
    add_space();
    if (depth > 0 && $urandom_range(0, 2) == 0) begin
      add_char(exprtok_pkg::CH_RPAREN);
      depth--;
    end
  endfunction

  // well-formed expression, or a damaged one with stray, dropped or doubled bytes
  function automatic void build_expr(int terms, bit damaged);
    int depth;
    int idx;
    depth = 0;
    expr_chars.delete();
    for (int i = 0; i < terms; i++) add_term(i == 0, depth);
    repeat (depth) add_char(exprtok_pkg::CH_RPAREN);
    if (damaged && expr_chars.size() > 0) begin
      repeat ($urandom_range(1, 2)) begin
        idx = $urandom_range(0, expr_chars.size() - 1);
        case ($urandom_range(0, 2))
          0: expr_chars.insert(idx, 8'($urandom_range(0, 255)));
          1: expr_chars.delete(idx);
          default: expr_chars.insert(idx, expr_chars[idx]);
        endcase
      end
    end
  endfunction

  // main sequence
  initial begin
    int base;
    in_valid       <= 1'b0;
    in_character   <= 8'h00;
    in_end_of_expr <= 1'b0;
    rst_n          <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty expression, every operator, unary and binary minus,
    // signed exponent, second dot, whitespace at both ends and trailing stray bytes
    expr_chars.delete();
    send_expr();
    load_text("-.5e+2-x^(-y,_z)*3/+-");
    send_expr();
    expr_chars.delete();
    load_text(" 1.2.3\t");
    add_char(8'hFF);
    add_char(8'h00);
    send_expr();

    // random expressions, mostly well-formed
    while (sb.words_taken < RANDOM_WORDS) begin
      build_expr($urandom_range(1, 8), $urandom_range(0, 9) < 3);
      send_expr();
      if ($urandom_range(0, 15) == 0) settle();
    end

    // long receiver hold-off while the sender keeps the input full
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    steady = 1'b1;
    base = sb.words_taken;
    while (sb.words_taken < base + 150) begin
      build_expr(8, 1'b0);
      send_expr();
    end
    steady = 1'b0;

    // drain and let any stray token show up
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d words in %0d expressions, %0d tokens checked, longest token %0d",
             sb.words_taken, sb.expressions, sb.tokens_checked, sb.longest);
    $display("token kinds seen: %0d of 13", $countones(sb.kinds_seen));
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
